@@ rtl/ufpe_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufpe_pkg: shared types and constants
// Result codes, phases, character codes and the queue entry layout for the
// form parameter extractor.
// ----------------------------------------------------------------------------
package ufpe_pkg;

  // Default largest key length in characters
  localparam int KeyMaxDefault = 8;

  // Result queue depth: room for the three results one byte can raise
  localparam int QueueDepth = 4;
  localparam int QueueAw    = $clog2(QueueDepth);

  // Configuration register indexes
  localparam logic [1:0] CFG_KEY_TEXT   = 2'd0;
  localparam logic [1:0] CFG_KEY_LENGTH = 2'd1;
  localparam logic [1:0] CFG_MAX_LENGTH = 2'd2;

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LOWA  = 8'h61;
  localparam logic [7:0] CASE_BIT = 8'h20;
  localparam logic [7:0] HEX_TEN  = 8'd10;

  localparam logic [63:0] KEY_TEXT_RESET = 64'd1701667182; // "name"
  localparam logic [3:0]  KEY_LENGTH_RESET = 4'd4;
  localparam logic [7:0]  MAX_LENGTH_RESET = 8'd63;

  localparam logic [3:0] KEY_POS_SAT = 4'd15;

  typedef enum logic [1:0] {
    KIND_BYTE      = 2'd0,
    KIND_FOUND     = 2'd1,
    KIND_NOT_FOUND = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    PH_MATCH = 2'd0,
    PH_SKIP  = 2'd1,
    PH_VALUE = 2'd2,
    PH_DONE  = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    ESC_NONE = 2'd0,
    ESC_HIGH = 2'd1,
    ESC_LOW  = 2'd2,
    ESC_RSVD = 2'd3
  } esc_e;

  // One result as held in the queue
  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic [7:0] len;
    logic       last;
  } res_t;

  // Results raised by one byte, in order
  typedef struct packed {
    logic [1:0]     n;
    res_t [2:0]     res;
  } push_t;

endpackage

@@ rtl/ufpe_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufpe_step: per-byte decoder
// Holds the parse state and turns one registered byte into up to three
// results in a single pass.
// ----------------------------------------------------------------------------
module ufpe_step #(
  parameter int KEY_MAX = ufpe_pkg::KeyMaxDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  logic [7:0]        char_i,
  input  logic [63:0]       key_text_i,
  input  logic [3:0]        key_length_i,
  input  logic [7:0]        max_len_i,
  output ufpe_pkg::push_t   push_o
);

  typedef struct packed {
    ufpe_pkg::phase_e phase;
    logic [3:0]       key_pos;
    logic             mismatch;
    ufpe_pkg::esc_e   esc;
    logic [7:0]       held;
    logic [7:0]       count;
  } state_t;

  typedef struct packed {
    ufpe_pkg::phase_e   ph;
    logic [7:0]         cnt;
    logic [1:0]         n;
    ufpe_pkg::res_t [2:0] res;
  } acc_t;

  state_t st_q, st_d;
  acc_t   acc;
  logic [3:0] klen;
  logic [7:0] hex_hi;
  logic [7:0] hex_lo;
  logic [7:0] hex_b;

  function automatic acc_t put_f(acc_t a, ufpe_pkg::kind_e k, logic [7:0] b, logic [7:0] l);
    acc_t r;
    r = a;
    unique case (a.n)
      2'd0: r.res[0] = '{kind: k, data: b, len: l, last: 1'b0};
      2'd1: r.res[1] = '{kind: k, data: b, len: l, last: 1'b0};
      2'd2: r.res[2] = '{kind: k, data: b, len: l, last: 1'b0};
      default: ;
    endcase
    if (a.n != 2'd3) r.n = a.n + 2'd1;
    return r;
  endfunction

  function automatic acc_t found_f(acc_t a);
    acc_t r;
    r = put_f(a, ufpe_pkg::KIND_FOUND, 8'd0, a.cnt);
    r.ph = ufpe_pkg::PH_DONE;
    return r;
  endfunction

  function automatic acc_t emit_f(acc_t a, logic [7:0] b, logic [7:0] max);
    acc_t r;
    r = a;
    if (a.ph == ufpe_pkg::PH_VALUE) begin
      r = put_f(r, ufpe_pkg::KIND_BYTE, b, 8'd0);
      r.cnt = r.cnt + 8'd1;
      if (r.cnt >= max) r = found_f(r);
    end
    return r;
  endfunction

  function automatic logic [7:0] hex_f(logic [7:0] x);
    logic [7:0] v;
    if (x >= ufpe_pkg::CH_ZERO && x <= ufpe_pkg::CH_NINE) v = x - ufpe_pkg::CH_ZERO;
    else v = (x | ufpe_pkg::CASE_BIT) - ufpe_pkg::CH_LOWA + ufpe_pkg::HEX_TEN;
    return v;
  endfunction

  assign klen   = (key_length_i > 4'(KEY_MAX)) ? 4'(KEY_MAX) : key_length_i;
  assign hex_hi = hex_f(st_q.held);
  assign hex_lo = hex_f(char_i);
  // high digit keeps its low nibble only; low digit may spill over
  assign hex_b  = {hex_hi[3:0], 4'h0} | hex_lo;

  always_comb begin
    st_d = st_q;
    acc  = '{ph: st_q.phase, cnt: st_q.count, n: 2'd0, res: '0};

    if (char_i == ufpe_pkg::CH_NUL) begin
      unique case (st_q.phase)
        ufpe_pkg::PH_MATCH, ufpe_pkg::PH_SKIP: begin
          acc = put_f(acc, ufpe_pkg::KIND_NOT_FOUND, 8'd0, 8'd0);
        end
        ufpe_pkg::PH_VALUE: begin
          // cut escape: literal percent, then the held digit as plain data
          if (st_q.esc != ufpe_pkg::ESC_NONE) acc = emit_f(acc, ufpe_pkg::CH_PCT, max_len_i);
          if (st_q.esc == ufpe_pkg::ESC_LOW && acc.ph == ufpe_pkg::PH_VALUE) begin
            if (st_q.held == ufpe_pkg::CH_AMP) acc = found_f(acc);
            else if (st_q.held == ufpe_pkg::CH_PLUS)
              acc = emit_f(acc, ufpe_pkg::CH_SPACE, max_len_i);
            else acc = emit_f(acc, st_q.held, max_len_i);
          end
          if (acc.ph == ufpe_pkg::PH_VALUE) acc = found_f(acc);
        end
        ufpe_pkg::PH_DONE: ;
      endcase
      st_d = '{phase: ufpe_pkg::PH_MATCH, key_pos: 4'd0, mismatch: 1'b0,
               esc: ufpe_pkg::ESC_NONE, held: 8'd0, count: 8'd0};
    end else begin
      unique case (st_q.phase)
        ufpe_pkg::PH_MATCH: begin
          if (char_i == ufpe_pkg::CH_EQ) begin
            if (!st_q.mismatch && st_q.key_pos == klen) begin
              acc.ph   = ufpe_pkg::PH_VALUE;
              acc.cnt  = 8'd0;
              st_d.esc = ufpe_pkg::ESC_NONE;
              if (max_len_i == 8'd0) acc = found_f(acc);
            end else begin
              acc.ph = ufpe_pkg::PH_SKIP;
            end
          end else if (char_i == ufpe_pkg::CH_AMP) begin
            st_d.key_pos  = 4'd0;
            st_d.mismatch = 1'b0;
          end else begin
            if (st_q.key_pos >= klen ||
                key_text_i[{st_q.key_pos[2:0], 3'b000} +: 8] != char_i)
              st_d.mismatch = 1'b1;
            if (st_q.key_pos < ufpe_pkg::KEY_POS_SAT) st_d.key_pos = st_q.key_pos + 4'd1;
          end
        end
        ufpe_pkg::PH_SKIP: begin
          if (char_i == ufpe_pkg::CH_AMP) begin
            acc.ph        = ufpe_pkg::PH_MATCH;
            st_d.key_pos  = 4'd0;
            st_d.mismatch = 1'b0;
          end
        end
        ufpe_pkg::PH_VALUE: begin
          unique case (st_q.esc)
            ufpe_pkg::ESC_HIGH: begin
              st_d.held = char_i;
              st_d.esc  = ufpe_pkg::ESC_LOW;
            end
            ufpe_pkg::ESC_LOW: begin
              st_d.esc = ufpe_pkg::ESC_NONE;
              acc = emit_f(acc, hex_b, max_len_i);
            end
            ufpe_pkg::ESC_NONE, ufpe_pkg::ESC_RSVD: begin
              if (char_i == ufpe_pkg::CH_AMP) acc = found_f(acc);
              else if (char_i == ufpe_pkg::CH_PLUS)
                acc = emit_f(acc, ufpe_pkg::CH_SPACE, max_len_i);
              else if (char_i == ufpe_pkg::CH_PCT) st_d.esc = ufpe_pkg::ESC_HIGH;
              else acc = emit_f(acc, char_i, max_len_i);
            end
          endcase
        end
        ufpe_pkg::PH_DONE: ;
      endcase
      st_d.phase = acc.ph;
      st_d.count = acc.cnt;
      if (acc.ph == ufpe_pkg::PH_DONE) st_d.esc = ufpe_pkg::ESC_NONE;
    end

    // flag the final result of this byte
    unique case (acc.n)
      2'd1: acc.res[0].last = 1'b1;
      2'd2: acc.res[1].last = 1'b1;
      2'd3: acc.res[2].last = 1'b1;
      default: ;
    endcase
  end

  assign push_o = '{n: adv_i ? acc.n : 2'd0, res: acc.res};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{phase: ufpe_pkg::PH_MATCH, key_pos: 4'd0, mismatch: 1'b0,
                esc: ufpe_pkg::ESC_NONE, held: 8'd0, count: 8'd0};
    end else if (adv_i) begin
      st_q <= st_d;
    end
  end

endmodule

@@ rtl/ufpe_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufpe_queue: result queue
// Takes up to three results a cycle, hands one out per output request.
// ----------------------------------------------------------------------------
module ufpe_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ufpe_pkg::push_t      push_i,
  input  logic                 pop_i,
  output ufpe_pkg::res_t       head_o,
  output logic                 valid_o,
  output logic                 room_o
);

  localparam int Aw = ufpe_pkg::QueueAw;

  ufpe_pkg::res_t [ufpe_pkg::QueueDepth-1:0] mem_q;
  logic [Aw-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [Aw:0]   cnt_q, cnt_d;
  logic          pop;

  assign valid_o = (cnt_q != '0);
  assign pop     = pop_i && valid_o;
  assign head_o  = mem_q[rp_q];
  // room for a full burst of three
  assign room_o  = (cnt_q <= (Aw+1)'(ufpe_pkg::QueueDepth - 3));

  assign wp_d  = wp_q + Aw'(push_i.n);
  assign rp_d  = rp_q + Aw'(pop);
  assign cnt_d = cnt_q + (Aw+1)'(push_i.n) - (Aw+1)'(pop);

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      if (i < int'(push_i.n)) mem_q[wp_q + Aw'(i)] <= push_i.res[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

@@ rtl/url_form_param_extractor.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// url_form_param_extractor: query string parameter finder and decoder
// Scans a form-encoded string byte by byte, finds the configured key and
// streams its percent/plus decoded value, then a found or not-found result.
// ----------------------------------------------------------------------------
//
//  channel  | handshake               | payload
//  ---------+-------------------------+------------------------------------
//  input    | in_valid_i / in_ready_o | char_in_i
//  output   | out_valid_o/out_ready_i | kind_o, out_byte_o, value_length_o,
//           |                         | last_of_run_o
//  config   | cfg_we_i (no wait)      | cfg_idx_i, cfg_wdata_i
//
// A request is registered on entry and decoded in one pass when the queue
// has room, its results landing in a four-entry queue; out_valid_o rises
// once the queue registers a result. One byte per cycle while each byte
// raises one result at most and the output keeps up; decode, and so input,
// waits while the queue holds two or more results. Ready is registered only.
// Reset clears parse state and queue, restores key "name", length 4, cap 63.
// ----------------------------------------------------------------------------
module url_form_param_extractor #(
  parameter int KEY_MAX = ufpe_pkg::KeyMaxDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input bytes
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  char_in_i,
  // results
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  out_byte_o,
  output logic [7:0]  value_length_o,
  output logic        last_of_run_o,
  // configuration
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_wdata_i
);

  // configuration registers
  logic [63:0] key_text_q;
  logic [3:0]  key_len_q;
  logic [7:0]  max_len_q;

  // input stage
  logic        in_vld_q;
  logic [7:0]  char_q;
  logic        adv;
  logic        room;

  ufpe_pkg::push_t push;
  ufpe_pkg::res_t  head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_text_q <= ufpe_pkg::KEY_TEXT_RESET;
      key_len_q  <= ufpe_pkg::KEY_LENGTH_RESET;
      max_len_q  <= ufpe_pkg::MAX_LENGTH_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ufpe_pkg::CFG_KEY_TEXT:   key_text_q <= cfg_wdata_i;
        ufpe_pkg::CFG_KEY_LENGTH: key_len_q  <= cfg_wdata_i[3:0];
        ufpe_pkg::CFG_MAX_LENGTH: max_len_q  <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // decode fires when a byte is held and the queue can take a full burst
  assign adv        = in_vld_q && room;
  assign in_ready_o = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) char_q <= char_in_i;
  end

  ufpe_step #(
    .KEY_MAX (KEY_MAX)
  ) u_step (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .char_i       (char_q),
    .key_text_i   (key_text_q),
    .key_length_i (key_len_q),
    .max_len_i    (max_len_q),
    .push_o       (push)
  );

  ufpe_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (out_ready_i),
    .head_o  (head),
    .valid_o (out_valid_o),
    .room_o  (room)
  );

  assign kind_o         = head.kind;
  assign out_byte_o     = head.data;
  assign value_length_o = head.len;
  assign last_of_run_o  = head.last;

endmodule
